@@ rtl/multigranular_lock_table_top_assert.svh @@
// Assertion macros for the lock table top level
`ifndef MULTIGRANULAR_LOCK_TABLE_TOP_ASSERT_SVH
`define MULTIGRANULAR_LOCK_TABLE_TOP_ASSERT_SVH
`define MLT_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("lock table check failed");
`define MLT_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("lock table check failed");
`endif

@@ rtl/mlt_pkg.sv @@
// Types and constants of the lock table
`timescale 1ns / 1ps
`default_nettype none
package mlt_pkg;
  localparam logic [1:0] REQ_TABLE = 2'd0;
  localparam logic [1:0] REQ_ROW = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;
  localparam logic [1:0] MODE_IS = 2'd0;
  localparam logic [1:0] MODE_IX = 2'd1;
  localparam logic [1:0] MODE_S = 2'd2;
  localparam logic [1:0] MODE_X = 2'd3;
  localparam logic [2:0] ST_GRANTED = 3'd0;
  localparam logic [2:0] ST_WAIT_TABLE = 3'd1;
  localparam logic [2:0] ST_WAIT_ROW = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_RELEASED = 3'd4;
  localparam logic [1:0] GRES_GRANT = 2'd0;
  localparam logic [1:0] GRES_WAIT = 2'd1;
  localparam logic [1:0] GRES_APPEND = 2'd2;
  localparam logic [1:0] GRES_FULL = 2'd3;

  typedef struct packed {
    logic [15:0] tx;
    logic [7:0] tab;
    logic isrow;
    logic [31:0] key;
    logic [1:0] mode;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_REL, S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch request
    logic tab_req;   // request is a table lock
    logic scan_start;// start a grant scan, phase row if isrow
    logic isrow;
    logic scan_step;
    logic decide;    // apply grant decision
    logic rel_start;
    logic rel_step;
    logic finish_rel;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic rel_done;
    logic [1:0] gres; // grant, wait or full
  } sts_t;

  function automatic logic compat(input logic [1:0] e, input logic [1:0] r);
    logic [3:0] row;
    unique case (e)
      MODE_IS: row = 4'b0111;
      MODE_IX: row = 4'b0011;
      MODE_S:  row = 4'b0101;
      default: row = 4'b0000;
    endcase
    return row[r];
  endfunction
endpackage
`default_nettype wire

@@ rtl/mlt_if.sv @@
// Valid/ready channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface mlt_req_if;
  logic valid;
  logic ready;
  logic [1:0] req_type;
  logic [15:0] tx_id;
  logic [7:0] table_id;
  logic signed [31:0] row_key;
  logic [1:0] lock_mode;
  modport source (output valid, req_type, tx_id, table_id, row_key, lock_mode,
                  input ready);
  modport sink (input valid, req_type, tx_id, table_id, row_key, lock_mode,
                output ready);
endinterface

interface mlt_rsp_if;
  logic valid;
  logic ready;
  logic [2:0] status;
  logic [6:0] removed_count;
  modport source (output valid, status, removed_count, input ready);
  modport sink (input valid, status, removed_count, output ready);
endinterface
`default_nettype wire

@@ rtl/multigranular_lock_table_top.sv @@
// Multiple-granularity lock table, top level
// One request at a time. The entry memory has a single read port, which is
// swept over the entries in use (at most ENTRY_COUNT) once per resource
// checked and once for the compacting pass of a release. No clearing pass is
// needed after reset.
`timescale 1ns / 1ps
`default_nettype none
module multigranular_lock_table_top #(
  parameter int ENTRY_COUNT = 64
) (
  input wire logic clk,
  input wire logic rst_n,
  mlt_req_if.sink in_ch,
  mlt_rsp_if.source out_ch
);
  import mlt_pkg::*;
  `include "multigranular_lock_table_top_assert.svh"
  cmd_t cmd;
  sts_t sts;
  logic busy, ov, swe;
  logic [2:0] snxt, status_r;
  logic [6:0] rem;
  wire logic in_fire = in_ch.valid && in_ch.ready;
  wire logic out_fire = ov && out_ch.ready;

  assign in_ch.ready = !busy;
  mlt_ctrl u_ctrl (.clk, .rst_n, .in_fire, .req_type(in_ch.req_type),
    .tx_zero(in_ch.tx_id == 16'd0), .out_fire, .sts, .cmd, .busy,
    .out_valid(ov), .status_nxt(snxt), .status_we(swe));
  mlt_dp #(.ENTRY_COUNT(ENTRY_COUNT)) u_dp (.clk, .rst_n, .cmd,
    .tx_in(in_ch.tx_id), .tab_in(in_ch.table_id), .key_in(in_ch.row_key),
    .mode_in(in_ch.lock_mode), .sts, .removed_count(rem));

  always_ff @(posedge clk) if (swe) status_r <= snxt;
  assign out_ch.valid = ov;
  assign out_ch.status = status_r;
  assign out_ch.removed_count = (status_r == ST_RELEASED) ? rem : 7'd0;

  `MLT_ASSERT_IMPL(a_no_accept_busy, out_ch.valid, !in_ch.ready)
  `MLT_ASSERT_NEXT(a_out_after_fire_idle, out_fire, in_ch.ready)
  `MLT_ASSERT_IMPL(a_status_range, out_ch.valid, out_ch.status <= ST_RELEASED)
endmodule
`default_nettype wire

@@ rtl/mlt_ctrl.sv @@
// Sequencer of the lock table
`timescale 1ns / 1ps
`default_nettype none
module mlt_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire logic [1:0] req_type,
  input  wire logic tx_zero,
  input  wire logic out_fire,
  input  wire mlt_pkg::sts_t sts,
  output mlt_pkg::cmd_t cmd,
  output logic busy,
  output logic out_valid,
  output logic [2:0] status_nxt,
  output logic status_we
);
  import mlt_pkg::*;
  state_t state_r, state_nxt;
  logic phase_r, phase_nxt;
  logic [1:0] req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
    if (in_fire) req_r <= req_type;
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    unique case (state_r)
      S_IDLE: if (in_fire) begin
        phase_nxt = 1'b0;
        if (req_type == REQ_RELEASE) state_nxt = S_REL;
        else if ((req_type == REQ_TABLE || req_type == REQ_ROW) && !tx_zero)
          state_nxt = S_SCAN;
        else state_nxt = S_OUT;
      end
      S_SCAN: if (sts.scan_done) state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (sts.gres == GRES_GRANT && req_r == REQ_ROW && !phase_r) begin
          phase_nxt = 1'b1;
          state_nxt = S_SCAN;
        end else state_nxt = S_OUT;
      end
      S_REL: if (sts.rel_done) state_nxt = S_OUT;
      S_OUT: if (out_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    status_we = 1'b0;
    status_nxt = ST_GRANTED;
    busy = state_r != S_IDLE;
    out_valid = state_r == S_OUT;
    cmd.isrow = phase_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_fire;
        cmd.tab_req = req_type == REQ_TABLE;
        cmd.scan_start = in_fire;
        cmd.isrow = 1'b0;
        cmd.rel_start = in_fire && req_type == REQ_RELEASE;
        status_we = in_fire;
        status_nxt = (req_type == REQ_RELEASE) ? ST_RELEASED : ST_GRANTED;
      end
      S_SCAN: cmd.scan_step = 1'b1;
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.gres == GRES_GRANT && req_r == REQ_ROW && !phase_r) begin
          cmd.scan_start = 1'b1;
          cmd.isrow = 1'b1;
        end
        status_we = 1'b1;
        if (sts.gres == GRES_WAIT) status_nxt = phase_r ? ST_WAIT_ROW : ST_WAIT_TABLE;
        else if (sts.gres == GRES_FULL) status_nxt = ST_FULL;
      end
      S_REL: begin
        cmd.rel_step = 1'b1;
        cmd.finish_rel = sts.rel_done;
      end
      S_OUT: ;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

@@ rtl/mlt_dp.sv @@
// Entry memory, scan and compaction datapath of the lock table
`timescale 1ns / 1ps
`default_nettype none
module mlt_dp #(
  parameter int ENTRY_COUNT = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire mlt_pkg::cmd_t cmd,
  input  wire logic [15:0] tx_in,
  input  wire logic [7:0] tab_in,
  input  wire logic [31:0] key_in,
  input  wire logic [1:0] mode_in,
  output mlt_pkg::sts_t sts,
  output logic [6:0] removed_count
);
  import mlt_pkg::*;
  localparam int AW = $clog2(ENTRY_COUNT);
  localparam int CW = $clog2(ENTRY_COUNT + 1);

  entry_t mem [ENTRY_COUNT];
  entry_t rd_r;
  logic [CW-1:0] used_r, ptr_r, wp_r;
  logic rd_v_r, issue_done_r;
  logic [15:0] tx_r;
  logic [7:0] tab_r;
  logic [31:0] key_r;
  logic [1:0] mode_r, umode;
  logic isrow_r;
  logic tab_is_req_r;
  logic found_r, conflict_r, others_r;
  logic [AW-1:0] first_r;
  logic [1:0] fmode_r;
  logic [6:0] rem_r;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  entry_t wr_data;
  logic [1:0] gres;

  // mode of the current phase
  always_comb begin
    umode = mode_r;
    if (!isrow_r) begin
      if (mode_r == MODE_S) umode = MODE_IS;
      else if (mode_r == MODE_X) umode = MODE_IX;
    end
  end

  wire logic [1:0] use_mode = (isrow_r || tab_is_req_r) ? mode_r : umode;

  wire logic same = rd_v_r && rd_r.tab == tab_r && rd_r.isrow == isrow_r &&
                    (!isrow_r || rd_r.key == key_r);
  wire logic more = ptr_r < used_r;

  always_comb begin
    gres = GRES_GRANT;
    if (found_r && (fmode_r == MODE_X || use_mode == MODE_S) && !conflict_r)
      gres = GRES_GRANT;
    else if (found_r && use_mode == MODE_X && (fmode_r == MODE_X || !others_r) &&
             !conflict_r) gres = GRES_GRANT;
    else if (conflict_r) gres = GRES_WAIT;
    else if (used_r >= CW'(ENTRY_COUNT)) gres = GRES_FULL;
    else gres = GRES_APPEND;
  end

  assign sts.gres = (gres == GRES_APPEND) ? GRES_GRANT : gres;
  assign sts.scan_done = issue_done_r && !rd_v_r;
  assign sts.rel_done = issue_done_r && !rd_v_r;
  assign removed_count = rem_r;

  always_comb begin
    wr_en = 1'b0;
    wr_addr = '0;
    wr_data = rd_r;
    if (cmd.decide) begin
      if (gres == GRES_APPEND) begin
        wr_en = 1'b1;
        wr_addr = used_r[AW-1:0];
        wr_data.tx = tx_r;
        wr_data.tab = tab_r;
        wr_data.isrow = isrow_r;
        wr_data.key = isrow_r ? key_r : 32'd0;
        wr_data.mode = use_mode;
      end else if (found_r && use_mode == MODE_X && fmode_r != MODE_X && !others_r) begin
        wr_en = 1'b1;
        wr_addr = first_r;
        wr_data = '0;
        wr_data.mode = MODE_X;
      end
    end else if (cmd.rel_step && rd_v_r && rd_r.tx != tx_r) begin
      wr_en = 1'b1;
      wr_addr = wp_r[AW-1:0];
    end
  end

  logic upg_only;
  assign upg_only = cmd.decide && gres != GRES_APPEND;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (upg_only) mem[wr_addr].mode <= MODE_X;
      else mem[wr_addr] <= wr_data;
    end
    rd_r <= mem[ptr_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      rd_v_r <= 1'b0;
      issue_done_r <= 1'b0;
    end else begin
      if (cmd.decide && gres == GRES_APPEND) used_r <= used_r + CW'(1);
      if (cmd.finish_rel) used_r <= wp_r;
      if (cmd.scan_start || cmd.rel_start) begin
        rd_v_r <= 1'b0;
        issue_done_r <= 1'b0;
      end else if (cmd.scan_step || cmd.rel_step) begin
        rd_v_r <= more && !issue_done_r;
        if (!more) issue_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tx_r <= tx_in;
      tab_r <= tab_in;
      key_r <= key_in;
      mode_r <= mode_in;
      rem_r <= '0;
      wp_r <= '0;
    end
    if (cmd.scan_start) begin
      isrow_r <= cmd.isrow;
      tab_is_req_r <= cmd.load ? cmd.tab_req : tab_is_req_r;
      ptr_r <= '0;
      found_r <= 1'b0;
      conflict_r <= 1'b0;
      others_r <= 1'b0;
    end else if (cmd.scan_step || cmd.rel_step) begin
      if (more && !issue_done_r) ptr_r <= ptr_r + CW'(1);
      if (cmd.scan_step && same) begin
        if (rd_r.tx == tx_r) begin
          if (!found_r) begin
            found_r <= 1'b1;
            first_r <= ptr_r[AW-1:0] - AW'(1);
            fmode_r <= rd_r.mode;
          end
        end else begin
          others_r <= 1'b1;
          if (!compat(rd_r.mode, use_mode)) conflict_r <= 1'b1;
        end
      end
      if (cmd.rel_step && rd_v_r) begin
        if (rd_r.tx == tx_r) begin
          if (rem_r != 7'd127) rem_r <= rem_r + 7'd1;
        end else wp_r <= wp_r + CW'(1);
      end
    end
  end
endmodule
`default_nettype wire
